FILE: hw/rtl/spaced_seed_shift_table_core_assert.svh
// Assertion macros shared by the spaced-seed shift table modules.
// SSST_ASSERT_IMPL checks a consequent in the same cycle as its antecedent.
// SSST_ASSERT_NEXT checks a consequent in the cycle after its antecedent.
`ifndef SPACED_SEED_SHIFT_TABLE_CORE_ASSERT_SVH
`define SPACED_SEED_SHIFT_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SSST_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SSST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SSST_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SSST_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/ssst_pkg.sv
`timescale 1ns / 1ps

package ssst_pkg;

  localparam int POS_W        = 6;
  localparam int CNT_W        = 7;
  localparam int SEED_W       = 64;
  localparam int CFG_IDX_W    = 1;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SEED_PATTERN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_LENGTH  = 1'b1;

  typedef struct packed {
    logic load;
    logic scan;
    logic rd;
    logic cmp_count;
    logic step;
    logic update;
    logic emit_entry;
    logic emit_empty;
    logic emit_bad;
  } cmd_t;

  typedef struct packed {
    logic bad_in;
    logic scan_last;
    logic pairs_done;
    logic tail_done;
    logic mismatch;
    logic n_zero;
    logic out_free;
  } status_t;

endpackage

FILE: hw/rtl/spaced_seed_shift_table_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Signals                          Contents
// s_axis    in         tvalid tready tdata[7:0]         shift_amount [5:0]
// m_axis    out        tvalid tready tdata[31:0] tuser  changed_position, ones_before_shift,
//                      tlast                            change_count, best_shift
// cfg       in         cfg_we cfg_index cfg_data[63:0]  0: seed_pattern, 1: seed_length
//
// Each shift works on the single position memory, read at two addresses per lookup,
// which is walked once to count the changes and once more to emit them; a bad shift skips
// both walks, and an empty list skips the second walk.
// Reset is synchronous and active high; it resets the config, held minimum, out_valid and FSM.
// A stalled output word holds the emission loop; the next shift is taken once its last
// word sits in the output register.
module spaced_seed_shift_table_core #(
  parameter int MAX_SEED_LEN = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ssst_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [5:0] shift_amount
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [5:0] changed_position, [12:6] ones_before_shift, [19:13] change_count,
  // [25:20] best_shift
  output logic [ssst_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                              m_axis_tuser,   // [0] position_valid
  output logic                              m_axis_tlast,
  input  logic                              cfg_we,
  input  logic [ssst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssst_pkg::SEED_W-1:0]       cfg_data
);

  ssst_pkg::cmd_t             cmd;
  ssst_pkg::status_t          status;
  logic [ssst_pkg::POS_W-1:0] changed_position;
  logic [ssst_pkg::CNT_W-1:0] ones_before_shift;
  logic [ssst_pkg::CNT_W-1:0] change_count;
  logic [ssst_pkg::POS_W-1:0] best_shift;

  ssst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ssst_datapath #(
    .MAX_SEED_LEN (MAX_SEED_LEN)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .shift_amount      (s_axis_tdata[ssst_pkg::POS_W-1:0]),
    .cmd               (cmd),
    .status            (status),
    .out_ready         (m_axis_tready),
    .out_valid         (m_axis_tvalid),
    .changed_position  (changed_position),
    .position_valid    (m_axis_tuser),
    .last_of_run       (m_axis_tlast),
    .ones_before_shift (ones_before_shift),
    .change_count      (change_count),
    .best_shift        (best_shift)
  );

  assign m_axis_tdata = {6'b0, best_shift, change_count, ones_before_shift, changed_position};

endmodule

FILE: hw/rtl/ssst_datapath.sv
`timescale 1ns / 1ps
`include "spaced_seed_shift_table_core_assert.svh"

module ssst_datapath #(
  parameter int MAX_SEED_LEN = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ssst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssst_pkg::SEED_W-1:0]   cfg_data,
  input  logic [ssst_pkg::POS_W-1:0]    shift_amount,
  input  ssst_pkg::cmd_t                cmd,
  output ssst_pkg::status_t             status,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [ssst_pkg::POS_W-1:0]    changed_position,
  output logic                          position_valid,
  output logic                          last_of_run,
  output logic [ssst_pkg::CNT_W-1:0]    ones_before_shift,
  output logic [ssst_pkg::CNT_W-1:0]    change_count,
  output logic [ssst_pkg::POS_W-1:0]    best_shift
);

  localparam int AW = $clog2(MAX_SEED_LEN);
  localparam logic [ssst_pkg::CNT_W-1:0] MAX_LEN = ssst_pkg::CNT_W'(MAX_SEED_LEN);

  logic [ssst_pkg::SEED_W-1:0] seed_pattern;
  logic [ssst_pkg::CNT_W-1:0]  seed_length;
  logic [ssst_pkg::POS_W-1:0]  shift;
  logic [ssst_pkg::CNT_W-1:0]  scan_k;
  logic [ssst_pkg::CNT_W-1:0]  ones_total;
  logic [ssst_pkg::CNT_W-1:0]  ones_before;
  logic [ssst_pkg::CNT_W-1:0]  idx;
  logic [ssst_pkg::CNT_W-1:0]  mism_count;
  logic [ssst_pkg::CNT_W-1:0]  emitted;
  logic [ssst_pkg::POS_W-1:0]  best_shift_held;
  logic [ssst_pkg::CNT_W-1:0]  best_count_held;
  logic [ssst_pkg::POS_W-1:0]  rd_a;
  logic [ssst_pkg::POS_W-1:0]  rd_b;
  logic [ssst_pkg::POS_W-1:0]  pos_mem [MAX_SEED_LEN];

  logic [ssst_pkg::CNT_W-1:0]  len_eff;
  logic [ssst_pkg::CNT_W-1:0]  pairs;
  logic [ssst_pkg::CNT_W-1:0]  idx_b;
  logic [ssst_pkg::CNT_W-1:0]  change_total;
  logic                        pattern_bit;
  logic                        emit_any;

  assign len_eff      = (seed_length > MAX_LEN) ? MAX_LEN : seed_length;
  assign pattern_bit  = seed_pattern[scan_k[ssst_pkg::POS_W-1:0]];
  assign pairs        = ones_total - ones_before;
  assign idx_b        = idx + ones_before;
  assign change_total = mism_count + ones_before;
  assign emit_any     = cmd.emit_entry | cmd.emit_empty | cmd.emit_bad;

  assign status.bad_in     = (shift_amount == '0) || ({1'b0, shift_amount} >= len_eff);
  assign status.scan_last  = ((scan_k + ssst_pkg::CNT_W'(1)) == len_eff);
  assign status.pairs_done = (idx == pairs);
  assign status.tail_done  = (idx == ones_total);
  assign status.mismatch   = (({1'b0, rd_a} + {1'b0, shift}) != {1'b0, rd_b});
  assign status.n_zero     = (change_total == '0);
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_pattern <= '0;
      seed_length  <= ssst_pkg::CNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssst_pkg::REG_SEED_PATTERN: seed_pattern <= cfg_data;
        ssst_pkg::REG_SEED_LENGTH:  seed_length  <= cfg_data[ssst_pkg::CNT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && pattern_bit) begin
      pos_mem[ones_total[AW-1:0]] <= scan_k[ssst_pkg::POS_W-1:0];
    end
    if (cmd.rd) begin
      rd_a <= pos_mem[idx[AW-1:0]];
      rd_b <= pos_mem[idx_b[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shift       <= shift_amount;
      scan_k      <= '0;
      ones_total  <= '0;
      ones_before <= '0;
      mism_count  <= '0;
    end
    if (cmd.scan) begin
      scan_k <= scan_k + ssst_pkg::CNT_W'(1);
      if (pattern_bit) begin
        ones_total <= ones_total + ssst_pkg::CNT_W'(1);
        if (scan_k < {1'b0, shift}) begin
          ones_before <= ones_before + ssst_pkg::CNT_W'(1);
        end
      end
    end
    if (cmd.cmp_count && status.mismatch) begin
      mism_count <= mism_count + ssst_pkg::CNT_W'(1);
    end
    priority if (cmd.load || cmd.update) begin
      idx <= '0;
    end else if (cmd.step) begin
      idx <= idx + ssst_pkg::CNT_W'(1);
    end
    priority if (cmd.update) begin
      emitted <= '0;
    end else if (cmd.emit_entry) begin
      emitted <= emitted + ssst_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_shift_held <= '0;
      best_count_held <= '0;
    end else if (cmd.update) begin
      if ((shift == ssst_pkg::POS_W'(1)) || !(best_count_held < change_total)) begin
        best_shift_held <= shift;
        best_count_held <= change_total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_any) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_entry) begin
      changed_position  <= idx[ssst_pkg::POS_W-1:0];
      position_valid    <= 1'b1;
      last_of_run       <= ((emitted + ssst_pkg::CNT_W'(1)) == change_total);
      ones_before_shift <= ones_before;
      change_count      <= change_total;
      best_shift        <= best_shift_held;
    end else if (cmd.emit_empty || cmd.emit_bad) begin
      changed_position  <= '0;
      position_valid    <= 1'b0;
      last_of_run       <= 1'b1;
      ones_before_shift <= cmd.emit_bad ? '0 : ones_before;
      change_count      <= '0;
      best_shift        <= best_shift_held;
    end
  end

  `SSST_ASSERT_IMPL(a_entry_in_list, clk, rst, cmd.emit_entry, idx < ones_total)
  `SSST_ASSERT_IMPL(a_entry_within_count, clk, rst, cmd.emit_entry, emitted < change_total)
  `SSST_ASSERT_IMPL(a_before_le_total, clk, rst, cmd.update, ones_before <= ones_total)

endmodule

FILE: hw/rtl/ssst_ctrl.sv
`timescale 1ns / 1ps
`include "spaced_seed_shift_table_core_assert.svh"

module ssst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ssst_pkg::status_t status,
  output ssst_pkg::cmd_t    cmd
);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_SCAN  = 10'b00_0000_0010,
    ST_CRD   = 10'b00_0000_0100,
    ST_CCMP  = 10'b00_0000_1000,
    ST_UPD   = 10'b00_0001_0000,
    ST_ERD   = 10'b00_0010_0000,
    ST_ECMP  = 10'b00_0100_0000,
    ST_TAIL  = 10'b00_1000_0000,
    ST_EMPTY = 10'b01_0000_0000,
    ST_BAD   = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.bad_in ? ST_BAD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = ST_CRD;
        end
      end
      ST_CRD: begin
        if (status.pairs_done) begin
          state_next = ST_UPD;
        end else begin
          cmd.rd     = 1'b1;
          state_next = ST_CCMP;
        end
      end
      ST_CCMP: begin
        cmd.cmp_count = 1'b1;
        cmd.step      = 1'b1;
        state_next    = ST_CRD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_next = status.n_zero ? ST_EMPTY : ST_ERD;
      end
      ST_ERD: begin
        if (status.pairs_done) begin
          state_next = ST_TAIL;
        end else begin
          cmd.rd     = 1'b1;
          state_next = ST_ECMP;
        end
      end
      ST_ECMP: begin
        if (!status.mismatch) begin
          cmd.step   = 1'b1;
          state_next = ST_ERD;
        end else if (status.out_free) begin
          cmd.emit_entry = 1'b1;
          cmd.step       = 1'b1;
          state_next     = ST_ERD;
        end
      end
      ST_TAIL: begin
        if (status.tail_done) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit_entry = 1'b1;
          cmd.step       = 1'b1;
        end
      end
      ST_EMPTY: begin
        if (status.out_free) begin
          cmd.emit_empty = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_BAD: begin
        if (status.out_free) begin
          cmd.emit_bad = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `SSST_ASSERT_IMPL(a_emit_needs_room, clk, rst, cmd.emit_entry || cmd.emit_empty || cmd.emit_bad, status.out_free)
  `SSST_ASSERT_NEXT(a_accept_starts, clk, rst, in_valid && in_ready, state == ST_SCAN || state == ST_BAD)
  `SSST_ASSERT_NEXT(a_update_to_emit, clk, rst, cmd.update, state == ST_ERD || state == ST_EMPTY)

endmodule
